/* sv/ccaprng_pkg.sv */
`default_nettype none

package ccaprng_pkg;

	localparam int WORD_COUNT = 6;
	localparam int WORD_W     = 32;
	localparam int IDX_W      = 3;
	localparam int MOD_W      = 16;
	localparam int MOD_CNT_W  = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [WORD_COUNT-1:0][WORD_W-1:0] words_t;
	typedef logic [IDX_W-1:0] idx_t;

	// Operation codes of the input item
	localparam logic OP_RESEED = 1'b0;
	localparam logic OP_DRAW   = 1'b1;

	// Per-word seed increments
	localparam words_t SEED_STEPS = {
		32'hd1a9fbe7, 32'h97327ae1, 32'h40dde76d,
		32'h3df3b646, 32'h96041893, 32'hf22d0e56
	};

	// Running sums of the seed increments: the word values for a zero seed
	function automatic words_t seed_base();
		words_t base;
		word_t acc;
		acc = '0;
		for (int i = 0; i < WORD_COUNT; i++) begin
			acc = acc + SEED_STEPS[i];
			base[i] = acc;
		end
		return base;
	endfunction

	localparam words_t SEED_BASE = seed_base();

	// Shared adder request and response
	typedef struct packed {
		word_t a;
		word_t b;
		logic  cin;
	} alu_req_t;

	typedef struct packed {
		word_t res;
		logic  lt;
	} alu_rsp_t;

	// Remainder unit request and status
	typedef struct packed {
		logic             start;
		logic [MOD_W-1:0] dividend;
		logic [MOD_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] rem;
	} mod_rsp_t;

	// Sequencer states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SEED  = 8'b0000_0010,
		ST_LOAD  = 8'b0000_0100,
		ST_CHAIN = 8'b0000_1000,
		ST_INC   = 8'b0001_0000,
		ST_FIX   = 8'b0010_0000,
		ST_MODST = 8'b0100_0000,
		ST_MOD   = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

/* sv/carry_chain_additive_prng_unit.sv */
// Reseed: the six words are set from the seed, one word per cycle, no result.
// Draw: 1 load + 5 carry-chain adds + 1..5 increment steps (+1 if the increment
//   ripples through word1) on one shared 32-bit adder, then a start step and
//   sixteen restoring steps in the bit-serial remainder unit, then a load of the
//   output register once it is free.
// One item at a time; a finished result waits in the output register.
// Reset (arst_n low): words take their zero-seed values, no result pending.
`default_nettype none

module carry_chain_additive_prng_unit
	import ccaprng_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [WORD_W-1:0] seed_value,
	input  logic [MOD_W-1:0]  modulus,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] raw_value,
	output logic [MOD_W-1:0]  bounded_value
);

	state_t           state_q;
	words_t           words_q;
	idx_t             idx_q;
	word_t            acc_q;
	logic             carry_q;
	logic [MOD_W-1:0] mod_q;
	logic             out_valid_q;
	word_t            raw_q;
	logic [MOD_W-1:0] bounded_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	mod_req_t mod_req;
	mod_rsp_t mod_rsp;
	word_t    rd_word;
	logic     in_xfer;
	logic     out_xfer;
	logic     out_free;
	logic     wr_en;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign rd_word  = words_q[idx_q];

	// Operand selection for the shared adder
	always_comb begin
		alu_req = '{a: '0, b: '0, cin: 1'b0};
		case (state_q)
			ST_SEED:  alu_req = '{a: acc_q, b: SEED_STEPS[idx_q], cin: 1'b0};
			ST_LOAD:  alu_req = '{a: '0, b: rd_word, cin: 1'b0};
			ST_CHAIN: alu_req = '{a: acc_q, b: rd_word, cin: carry_q};
			ST_INC:   alu_req = '{a: '0, b: rd_word, cin: 1'b1};
			ST_FIX:   alu_req = '{a: acc_q, b: '0, cin: 1'b1};
			default:  alu_req = '{a: '0, b: '0, cin: 1'b0};
		endcase
	end

	ccaprng_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign mod_req = '{start: (state_q == ST_MODST), dividend: acc_q[MOD_W-1:0],
		divisor: mod_q};

	ccaprng_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Word store write port
	assign wr_en = (state_q == ST_SEED) || (state_q == ST_CHAIN) ||
		(state_q == ST_INC) || (state_q == ST_FIX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= SEED_BASE;
		end else if (wr_en) begin
			words_q[idx_q] <= alu_rsp.res;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			carry_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (operation == OP_RESEED) begin
							state_q <= ST_SEED;
							idx_q   <= '0;
						end else begin
							state_q <= ST_LOAD;
							idx_q   <= idx_t'(WORD_COUNT - 1);
						end
					end
				end
				ST_SEED: begin
					if (idx_q == idx_t'(WORD_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LOAD: begin
					carry_q <= 1'b0;
					idx_q   <= idx_t'(WORD_COUNT - 2);
					state_q <= ST_CHAIN;
				end
				ST_CHAIN: begin
					carry_q <= alu_rsp.lt;
					if (idx_q == '0) begin
						idx_q   <= idx_t'(WORD_COUNT - 1);
						state_q <= ST_INC;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_INC: begin
					// lt marks a wrap to zero
					if (!alu_rsp.lt) begin
						state_q <= ST_MODST;
					end else if (idx_q == idx_t'(1)) begin
						idx_q   <= '0;
						state_q <= ST_FIX;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_FIX: begin
					state_q <= ST_MODST;
				end
				ST_MODST: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (mod_rsp.done && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Accumulator and captured modulus
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			acc_q <= seed_value;
			mod_q <= modulus;
		end else if ((state_q == ST_SEED) || (state_q == ST_LOAD) ||
			(state_q == ST_CHAIN) || (state_q == ST_FIX)) begin
			acc_q <= alu_rsp.res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_MOD) && mod_rsp.done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_MOD) && mod_rsp.done && out_free) begin
			raw_q     <= acc_q;
			bounded_q <= mod_rsp.rem;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign raw_value     = raw_q;
	assign bounded_value = bounded_q;

	// Checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < idx_t'(WORD_COUNT))
		else $error("word index out of range");

	a_reseed_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (operation == OP_RESEED) |=> (state_q == ST_SEED))
		else $error("reseed transfer did not enter seeding");

	a_result_from_mod: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_MOD) && $past(mod_rsp.done))
		else $error("result produced outside remainder completion");

	a_mod_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MODST) |=> (state_q == ST_MOD) && !mod_rsp.done)
		else $error("remainder unit not restarted");

endmodule

`default_nettype wire

/* sv/ccaprng_alu.sv */
`default_nettype none

module ccaprng_alu
	import ccaprng_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [WORD_W:0] full_sum;

	// a + b + cin, carry out dropped; lt flags a result below operand b
	always_comb begin
		full_sum = {1'b0, req.a} + {1'b0, req.b} + {{WORD_W{1'b0}}, req.cin};
		rsp.res  = full_sum[WORD_W-1:0];
		rsp.lt   = (full_sum[WORD_W-1:0] < req.b);
	end

endmodule

`default_nettype wire

/* sv/ccaprng_mod.sv */
`default_nettype none

module ccaprng_mod
	import ccaprng_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	logic [MOD_W-1:0]     rem_q;
	logic [MOD_W-1:0]     dvd_q;
	logic [MOD_W-1:0]     div_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [MOD_W:0]   shifted;
	logic [MOD_W+1:0] diff;
	logic             ge;
	logic [MOD_W-1:0] rem_next;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted  = {rem_q, dvd_q[MOD_W-1]};
		diff     = {1'b0, shifted} - {2'b00, div_q};
		ge       = ~diff[MOD_W+1];
		rem_next = ge ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
	end

	// Control: sixteen steps after start, done holds until the next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == {MOD_CNT_W{1'b1}}) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[MOD_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

/* verif/carry_chain_additive_prng_unit_test.sv */
`timescale 1ns / 100ps

module carry_chain_additive_prng_unit_test;
	import ccaprng_pkg::*;

	localparam int ITEM_COUNT   = 600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	// Receiver hold-off and quiet windows, in cycles since time zero
	localparam int HOLD_FROM    = 1500;
	localparam int HOLD_LEN     = 300;
	localparam int RX_QUIET_LO  = 6000;
	localparam int RX_QUIET_HI  = 8000;
	// Sender runs back to back for these random items
	localparam int TX_QUIET_LO  = 250;
	localparam int TX_QUIET_HI  = 350;
	localparam int DIR_ROWS     = 21;

	typedef struct packed {
		word_t            raw;
		logic [MOD_W-1:0] bounded;
	} draw_result_t;

	typedef struct packed {
		logic             op;
		word_t            seed;
		logic [MOD_W-1:0] md;
		logic             typed;
		logic [MOD_W-1:0] bounded;
	} dir_row_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic              operation     = OP_DRAW;
	logic [WORD_W-1:0] seed_value    = '0;
	logic [MOD_W-1:0]  modulus       = 16'h0001;
	logic              out_valid;
	logic              out_stall     = 1'b1;
	logic [WORD_W-1:0] raw_value;
	logic [MOD_W-1:0]  bounded_value;

	// Predicted generator state and bookkeeping
	words_t       gen_words;
	draw_result_t expected_draws[$];
	dir_row_t     dir_rows [DIR_ROWS];
	word_t        wrap_seed;
	int           mismatch_count = 0;
	int           draws_sent     = 0;
	int           reseeds_sent   = 0;
	int           results_seen   = 0;
	int           word5_wraps    = 0;
	int           cycle_count    = 0;
	int           rx_cycle       = 0;

	carry_chain_additive_prng_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.seed_value   (seed_value),
		.modulus      (modulus),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.raw_value    (raw_value),
		.bounded_value(bounded_value)
	);

	always #1 clk = ~clk;

	// Fixed per-word seed increments
	function automatic word_t seed_step(input int idx);
		case (idx)
			0: return 32'hf22d0e56;
			1: return 32'h96041893;
			2: return 32'h3df3b646;
			3: return 32'h40dde76d;
			4: return 32'h97327ae1;
			default: return 32'hd1a9fbe7;
		endcase
	endfunction

	function automatic void reseed_words(input word_t seed);
		word_t acc;
		acc = seed;
		for (int i = 0; i < WORD_COUNT; i++) begin
			acc = acc + seed_step(i);
			gen_words[i] = acc;
		end
	endfunction

	// One draw: add chain from word5/word4 down to word0, then bump the counter words
	function automatic word_t advance_words();
		word_t run;
		word_t prior;
		logic  cy;
		logic  ripple;
		run = gen_words[5] + gen_words[4];
		cy = (run < gen_words[5]) || (run < gen_words[4]);
		gen_words[4] = run;
		for (int i = 3; i >= 1; i--) begin
			prior = gen_words[i];
			run = run + prior + cy;
			cy = (run < prior);
			gen_words[i] = run;
		end
		run = run + gen_words[0] + cy;
		gen_words[0] = run;
		ripple = 1'b1;
		for (int i = 5; i >= 1; i--) begin
			if (ripple) begin
				gen_words[i] = gen_words[i] + 1;
				ripple = (gen_words[i] == '0);
				if (i == 5 && ripple)
					word5_wraps++;
			end
		end
		// Counter wrapped out of word1: accumulator picks up the extra one
		if (ripple) begin
			run = run + 1;
			gen_words[0] = run;
		end
		return run;
	endfunction

	function automatic draw_result_t predict_draw(input logic [MOD_W-1:0] md);
		draw_result_t res;
		logic [MOD_W-1:0] low;
		res.raw = advance_words();
		low = res.raw[MOD_W-1:0];
		res.bounded = (md == '0) ? low : low % md;
		return res;
	endfunction

	// Directed rows; bounded value typed in only where it is obvious
	function automatic void load_dir_rows();
		word_t base_sum;
		base_sum = '0;
		for (int i = 0; i < WORD_COUNT; i++)
			base_sum = base_sum + seed_step(i);
		// seed that puts word5 at all ones
		wrap_seed = 32'hffff_ffff - base_sum;
		dir_rows[0]  = '{OP_DRAW,   32'h0000_0000, 16'h0001, 1'b1, 16'h0000};
		dir_rows[1]  = '{OP_DRAW,   32'h0000_0000, 16'hffff, 1'b0, 16'h0000};
		dir_rows[2]  = '{OP_DRAW,   32'h0000_0000, 16'h0000, 1'b0, 16'h0000};
		dir_rows[3]  = '{OP_DRAW,   32'h0000_0000, 16'h0002, 1'b0, 16'h0000};
		dir_rows[4]  = '{OP_RESEED, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000};
		dir_rows[5]  = '{OP_DRAW,   32'h0000_0000, 16'h0001, 1'b1, 16'h0000};
		dir_rows[6]  = '{OP_RESEED, 32'hffff_ffff, 16'hffff, 1'b0, 16'h0000};
		dir_rows[7]  = '{OP_DRAW,   32'hffff_ffff, 16'hffff, 1'b0, 16'h0000};
		dir_rows[8]  = '{OP_DRAW,   32'h0000_0000, 16'h8000, 1'b0, 16'h0000};
		dir_rows[9]  = '{OP_RESEED, wrap_seed,     16'h0001, 1'b0, 16'h0000};
		dir_rows[10] = '{OP_DRAW,   32'h0000_0000, 16'h0001, 1'b1, 16'h0000};
		dir_rows[11] = '{OP_DRAW,   32'h0000_0000, 16'h5555, 1'b0, 16'h0000};
		dir_rows[12] = '{OP_RESEED, wrap_seed - 1, 16'h0000, 1'b0, 16'h0000};
		dir_rows[13] = '{OP_DRAW,   32'h0000_0000, 16'h0000, 1'b0, 16'h0000};
		dir_rows[14] = '{OP_DRAW,   32'h0000_0000, 16'h00ff, 1'b0, 16'h0000};
		dir_rows[15] = '{OP_RESEED, 32'h8000_0000, 16'h0000, 1'b0, 16'h0000};
		dir_rows[16] = '{OP_DRAW,   32'h0000_0000, 16'haaaa, 1'b0, 16'h0000};
		dir_rows[17] = '{OP_DRAW,   32'h0000_0000, 16'h0003, 1'b0, 16'h0000};
		// back-to-back reseeds: only the second one counts
		dir_rows[18] = '{OP_RESEED, 32'h1234_5678, 16'h0000, 1'b0, 16'h0000};
		dir_rows[19] = '{OP_RESEED, 32'h0000_0001, 16'h0000, 1'b0, 16'h0000};
		dir_rows[20] = '{OP_DRAW,   32'h0000_0000, 16'h0007, 1'b0, 16'h0000};
	endfunction

	function automatic int pick_gap(input bit quiet);
		int gap;
		gap = 0;
		if (!quiet)
			while ($urandom_range(0, 99) < 31)
				gap++;
		return gap;
	endfunction

	// Offer one item, hold it until the transfer, then record what it should produce
	task automatic push_item(input logic op, input word_t seed, input logic [MOD_W-1:0] md,
			input int gap, input logic typed, input logic [MOD_W-1:0] bounded);
		draw_result_t res;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		seed_value <= seed;
		modulus    <= md;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == OP_RESEED) begin
			reseed_words(seed);
			reseeds_sent++;
		end else begin
			res = predict_draw(md);
			if (typed)
				res.bounded = bounded;
			expected_draws.push_back(res);
			draws_sent++;
		end
	endtask

	// Reset and stimulus
	initial begin : drive_items
		logic             op;
		word_t            seed;
		logic [MOD_W-1:0] md;
		int               pick;
		reseed_words('0);
		load_dir_rows();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			push_item(dir_rows[i].op, dir_rows[i].seed, dir_rows[i].md, pick_gap(1'b0),
				dir_rows[i].typed, dir_rows[i].bounded);

		for (int i = 0; i < ITEM_COUNT; i++) begin
			op = ($urandom_range(0, 99) < 15) ? OP_RESEED : OP_DRAW;
			// a quarter of reseeds land word5 just below its wrap
			if ($urandom_range(0, 3) == 0)
				seed = wrap_seed - $urandom_range(0, 3);
			else
				seed = $urandom();
			pick = $urandom_range(0, 9);
			case (pick)
				0: md = '0;
				1: md = 16'h0001;
				2: md = 16'hffff;
				3, 4: md = MOD_W'($urandom_range(2, 15));
				default: md = MOD_W'($urandom_range(0, 65535));
			endcase
			push_item(op, seed, md, pick_gap(i >= TX_QUIET_LO && i < TX_QUIET_HI), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (expected_draws.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d draws and %0d reseeds, %0d results checked.",
			draws_sent, reseeds_sent, results_seen);
		$display("Counter word5 wrapped %0d times.", word5_wraps);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: random stalls, one long hold-off, one quiet window
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_LEN)
			out_stall <= 1'b1;
		else if (rx_cycle >= RX_QUIET_LO && rx_cycle < RX_QUIET_HI)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < 31);
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		draw_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_draws.size() == 0) begin
				$error("unexpected result transfer: raw_value %h bounded_value %h",
					raw_value, bounded_value);
				mismatch_count++;
			end else begin
				want = expected_draws.pop_front();
				if (raw_value !== want.raw) begin
					$error("raw_value mismatch: expected %h, actual %h", want.raw, raw_value);
					mismatch_count++;
				end
				if (bounded_value !== want.bounded) begin
					$error("bounded_value mismatch: expected %h, actual %h",
						want.bounded, bounded_value);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
